// ===== rtl/dfr_pkg.sv =====
`timescale 1ns / 1ps

package dfr_pkg;

	typedef logic [7:0] byte_t;

	// Largest frame the window holds; the ring itself is always 64 bytes deep
	localparam int FRAME_MAX_DEF = 64;

endpackage

// ===== rtl/dfr_queue.sv =====
`timescale 1ns / 1ps

module dfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dfr_pkg::byte_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dfr_pkg::byte_t out_data
);
	import dfr_pkg::*;

	localparam logic [1:0] QDEPTH = 2'd2;

	byte_t      slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != QDEPTH);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 2'd1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 2'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/dfr_engine.sv =====
`timescale 1ns / 1ps

module dfr_engine #(
	parameter int FRAME_MAX = dfr_pkg::FRAME_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dfr_pkg::byte_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dfr_pkg::byte_t frame_id,
	output logic [5:0]     data_count,
	output logic           has_data,
	output logic [5:0]     data_index,
	output dfr_pkg::byte_t data_byte,
	output logic           last,
	output logic [31:0]    frames_total,
	output logic [31:0]    resyncs_total
);
	import dfr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_FRM   = 3'd2;
	localparam logic [2:0] S_HDR   = 3'd3;
	localparam logic [2:0] S_DXOR  = 3'd4;
	localparam logic [2:0] S_ERD   = 3'd5;
	localparam logic [2:0] S_EWR   = 3'd6;
	localparam logic [2:0] S_EMPTY = 3'd7;

	localparam logic [1:0] POS_ID     = 2'd0;
	localparam logic [1:0] POS_LEN_LO = 2'd1;
	localparam logic [1:0] POS_LEN_HI = 2'd2;

	localparam logic [6:0] HDR_LEN   = 7'd4;
	localparam logic [6:0] SHORT_LEN = 7'd5;
	localparam logic [5:0] DATA_POS  = 6'd4;
	localparam logic [6:0] FMAX7     = 7'(FRAME_MAX);
	localparam logic [7:0] FMAX8     = 8'(FRAME_MAX);

	byte_t       ring_q [64];
	byte_t       rdata_q;
	logic [2:0]  state_q;
	logic [5:0]  head_q;
	logic [6:0]  fill_q;
	logic [6:0]  exp_q;
	logic [31:0] frame_cnt_q;
	logic [31:0] resync_cnt_q;
	logic [5:0]  iss_pos_q;
	logic [5:0]  iss_left_q;
	logic [5:0]  emit_pos_q;
	logic        tag_vld_q;
	logic [5:0]  tag_pos_q;
	byte_t       acc_q;
	byte_t       id_q;
	byte_t       lo_q;
	byte_t       hi_q;
	logic        out_valid_q;

	logic        pop;
	logic        out_free;
	logic        out_load;
	logic        emit_last;
	logic        rd_en;
	logic [5:0]  rd_pos;
	logic [5:0]  wr_addr;
	logic [5:0]  rd_addr;

	assign in_ready  = (state_q == S_IDLE);
	assign pop       = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && ((state_q == S_EWR) || (state_q == S_EMPTY));
	assign emit_last = (emit_pos_q == 6'(exp_q - 7'd2));
	assign wr_addr   = head_q + fill_q[5:0];
	assign rd_addr   = head_q + rd_pos;
	assign out_valid = out_valid_q;

	always_comb begin
		rd_en  = 1'b0;
		rd_pos = iss_pos_q;
		case (state_q)
			S_HDR, S_DXOR: begin
				rd_en = (iss_left_q != 6'd0);
			end
			S_ERD: begin
				rd_en  = 1'b1;
				rd_pos = emit_pos_q;
			end
			S_EWR: begin
				// fetch the next data byte as the current one moves out
				rd_en  = out_free && !emit_last;
				rd_pos = emit_pos_q + 6'd1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ring_q[wr_addr] <= in_data;
		end
		if (rd_en) begin
			rdata_q <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= 6'd0;
			fill_q        <= 7'd0;
			exp_q         <= 7'd0;
			frame_cnt_q   <= 32'd0;
			resync_cnt_q  <= 32'd0;
			iss_pos_q     <= 6'd0;
			iss_left_q    <= 6'd0;
			emit_pos_q    <= 6'd0;
			tag_vld_q     <= 1'b0;
			tag_pos_q     <= 6'd0;
			acc_q         <= '0;
			id_q          <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			out_valid_q   <= 1'b0;
			frame_id      <= '0;
			data_count    <= 6'd0;
			has_data      <= 1'b0;
			data_index    <= 6'd0;
			data_byte     <= '0;
			last          <= 1'b0;
			frames_total  <= 32'd0;
			resyncs_total <= 32'd0;
		end else begin
			tag_vld_q <= rd_en;
			tag_pos_q <= rd_pos;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (fill_q < FMAX7) begin
							fill_q <= fill_q + 7'd1;
						end else begin
							// window full: the oldest byte drops out of the window
							head_q       <= head_q + 6'd1;
							resync_cnt_q <= resync_cnt_q + 32'd1;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (fill_q < HDR_LEN) begin
						state_q <= S_IDLE;
					end else if (exp_q == 7'd0) begin
						iss_pos_q  <= 6'd0;
						iss_left_q <= 6'(HDR_LEN);
						acc_q      <= '0;
						state_q    <= S_HDR;
					end else if (fill_q < exp_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FRM;
					end
				end
				S_FRM: begin
					if (exp_q == HDR_LEN) begin
						frame_cnt_q <= frame_cnt_q + 32'd1;
						state_q     <= S_EMPTY;
					end else if (exp_q == SHORT_LEN) begin
						head_q       <= head_q + 6'd1;
						fill_q       <= fill_q - 7'd1;
						resync_cnt_q <= resync_cnt_q + 32'd1;
						exp_q        <= 7'd0;
						state_q      <= S_IDLE;
					end else begin
						iss_pos_q  <= DATA_POS;
						iss_left_q <= 6'(exp_q - HDR_LEN);
						acc_q      <= '0;
						state_q    <= S_DXOR;
					end
				end
				S_HDR: begin
					if (rd_en) begin
						iss_pos_q  <= iss_pos_q + 6'd1;
						iss_left_q <= iss_left_q - 6'd1;
					end
					if (tag_vld_q) begin
						case (tag_pos_q[1:0])
							POS_ID: begin
								id_q  <= rdata_q;
								acc_q <= acc_q ^ rdata_q;
							end
							POS_LEN_LO: begin
								lo_q  <= rdata_q;
								acc_q <= acc_q ^ rdata_q;
							end
							POS_LEN_HI: begin
								hi_q  <= rdata_q;
								acc_q <= acc_q ^ rdata_q;
							end
							default: begin
								// check byte: verify and range the length
								if ((rdata_q != acc_q) || (hi_q != 8'd0) ||
									(lo_q < 8'(HDR_LEN)) || (lo_q > FMAX8)) begin
									head_q       <= head_q + 6'd1;
									fill_q       <= fill_q - 7'd1;
									resync_cnt_q <= resync_cnt_q + 32'd1;
									state_q      <= S_IDLE;
								end else begin
									exp_q   <= lo_q[6:0];
									state_q <= S_CHK;
								end
							end
						endcase
					end
				end
				S_DXOR: begin
					if (rd_en) begin
						iss_pos_q  <= iss_pos_q + 6'd1;
						iss_left_q <= iss_left_q - 6'd1;
					end
					if (tag_vld_q) begin
						if (tag_pos_q == 6'(exp_q - 7'd1)) begin
							if (rdata_q == acc_q) begin
								frame_cnt_q <= frame_cnt_q + 32'd1;
								emit_pos_q  <= DATA_POS;
								state_q     <= S_ERD;
							end else begin
								head_q       <= head_q + 6'd1;
								fill_q       <= fill_q - 7'd1;
								resync_cnt_q <= resync_cnt_q + 32'd1;
								exp_q        <= 7'd0;
								state_q      <= S_IDLE;
							end
						end else begin
							acc_q <= acc_q ^ rdata_q;
						end
					end
				end
				S_ERD: begin
					state_q <= S_EWR;
				end
				S_EWR: begin
					if (out_free) begin
						frame_id      <= id_q;
						data_count    <= 6'(exp_q - SHORT_LEN);
						has_data      <= 1'b1;
						data_index    <= emit_pos_q - DATA_POS;
						data_byte     <= rdata_q;
						last          <= emit_last;
						frames_total  <= frame_cnt_q;
						resyncs_total <= resync_cnt_q;
						if (emit_last) begin
							// drop any surplus bytes with the frame
							fill_q  <= 7'd0;
							exp_q   <= 7'd0;
							state_q <= S_IDLE;
						end else begin
							emit_pos_q <= emit_pos_q + 6'd1;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						frame_id      <= id_q;
						data_count    <= 6'd0;
						has_data      <= 1'b0;
						data_index    <= 6'd0;
						data_byte     <= '0;
						last          <= 1'b1;
						frames_total  <= frame_cnt_q;
						resyncs_total <= resync_cnt_q;
						fill_q        <= 7'd0;
						exp_q         <= 7'd0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FMAX7)
		else $error("window fill beyond frame limit");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != 7'd0) |-> ((exp_q >= HDR_LEN) && (exp_q <= FMAX7)))
		else $error("accepted length out of range");

	a_fill_vs_exp: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (exp_q != 7'd0)) |-> (fill_q < exp_q))
		else $error("window waits with a complete frame buffered");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EWR) && out_free && emit_last) |=>
		((fill_q == 7'd0) && (exp_q == 7'd0) && out_valid_q && last))
		else $error("frame run did not close cleanly");
`endif

endmodule

// ===== rtl/xor_framed_byte_deframer.sv =====
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// input    in_valid / in_ready     rx_byte
// output   out_valid / out_ready   frame_id, data_count, has_data, data_index,
//                                  data_byte, last, frames_total, resyncs_total
//
// A byte that completes nothing passes S_IDLE and S_CHK; a header check reads the four header
// bytes. A completing frame walks its data and check bytes, then emits a data byte per cycle
// while out_ready allows; an empty frame is one beat. Reads share the single ring read port.
// A 2-entry input queue takes bytes while the engine works or stalls, until it is full.
// Reset clears counters and the window fill at once; there is no clearing pass.
module xor_framed_byte_deframer #(
	parameter int FRAME_MAX = dfr_pkg::FRAME_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dfr_pkg::byte_t rx_byte,
	output logic           out_valid,
	input  logic           out_ready,
	output dfr_pkg::byte_t frame_id,
	output logic [5:0]     data_count,
	output logic           has_data,
	output logic [5:0]     data_index,
	output dfr_pkg::byte_t data_byte,
	output logic           last,
	output logic [31:0]    frames_total,
	output logic [31:0]    resyncs_total
);
	import dfr_pkg::*;

	logic  q_valid;
	logic  q_ready;
	byte_t q_data;

	dfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (rx_byte),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	dfr_engine #(
		.FRAME_MAX (FRAME_MAX)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_ready      (q_ready),
		.in_data       (q_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_id      (frame_id),
		.data_count    (data_count),
		.has_data      (has_data),
		.data_index    (data_index),
		.data_byte     (data_byte),
		.last          (last),
		.frames_total  (frames_total),
		.resyncs_total (resyncs_total)
	);

endmodule
